/* rtl/core/assert_macros.svh */
// assertion macros for the snappy compressor core
// no dependencies; clk and rst are taken from the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SNPC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("snpc assertion failed");
`define SNPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("snpc assertion failed");
`else
`define SNPC_ASSERT_NOW(lbl, ante, cons)
`define SNPC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/core/snpc_pkg.sv */
// shared types and constants of the snappy block compressor
// no dependencies
package snpc_pkg;

  localparam int POS_W   = 17;
  localparam int ENTRY_W = 17;
  localparam logic [31:0] HASH_MUL = 32'h1e35a7bd;
  localparam int MIN_BLOCK = 16;

  // request kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] in_byte;
    logic       in_last;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       overflow;
  } res_t;

  // request to the hash unit
  typedef struct packed {
    logic               clear;
    logic               look;
    logic [31:0]        word;
    logic [ENTRY_W-1:0] pos1;
  } hash_req_t;

  // response of the hash unit
  typedef struct packed {
    logic               busy;
    logic               hit_valid;
    logic [ENTRY_W-1:0] seen;
  } hash_rsp_t;

  typedef enum logic [4:0] {
    ST_LOAD, ST_HDR, ST_CLEAR, ST_TOP, ST_WRD0, ST_WRD1, ST_WRD2, ST_LOOK,
    ST_WAIT, ST_CW0, ST_CW1, ST_CW2, ST_EXT, ST_EXTC, ST_LIT_HDR, ST_LIT_LEN,
    ST_LIT_DAT, ST_COPY, ST_END, ST_DRAIN, ST_FOUT
  } state_t;

endpackage

/* rtl/core/snpc_hash.sv */
// hash unit: word hash, position table and clearing sweep
// depends on snpc_pkg
module snpc_hash import snpc_pkg::*; #(
  parameter int HASH_BITS = 15
) (
  input  logic      clk,
  input  logic      rst,
  input  hash_req_t hreq,
  output hash_rsp_t hrsp
);

  localparam int HSIZE = 1 << HASH_BITS;

  logic [ENTRY_W-1:0]   tbl [HSIZE];
  logic [HASH_BITS-1:0] clr_idx;
  logic                 clr_busy;
  logic [HASH_BITS-1:0] h;
  logic                 look_d;
  logic [ENTRY_W-1:0]   pos1_d;
  logic [31:0]          prod;
  logic                 hit_valid;
  logic [ENTRY_W-1:0]   seen;

  assign prod = hreq.word * HASH_MUL;

  // clearing sweep and lookup control
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy  <= 1'b0;
      clr_idx   <= '0;
      look_d    <= 1'b0;
      hit_valid <= 1'b0;
    end else begin
      look_d    <= hreq.look;
      hit_valid <= look_d;
      if (hreq.clear) begin
        clr_busy <= 1'b1;
        clr_idx  <= '0;
      end else if (clr_busy) begin
        clr_idx <= clr_idx + 1'b1;
        if (clr_idx == HASH_BITS'(HSIZE - 1)) clr_busy <= 1'b0;
      end
    end
  end

  // hash stage
  always_ff @(posedge clk) begin
    h      <= prod[31 -: HASH_BITS];
    pos1_d <= hreq.pos1;
  end

  // table: read old value, write new position
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      tbl[clr_idx] <= '0;
    end else if (look_d) begin
      tbl[h] <= pos1_d;
    end
    if (look_d) seen <= tbl[h];
  end

  assign hrsp.busy      = clr_busy;
  assign hrsp.hit_valid = hit_valid;
  assign hrsp.seen      = seen;

endmodule

/* rtl/core/snappy_block_compressor.sv */
// Snappy block compressor. Load requests (kind 0) are taken one per cycle and
// write the block into block memory; the load with in_last set starts the
// compression, during which busy is high. A block over 15 bytes first goes
// through a hash table clearing pass. Each position then goes through hash,
// table read and decision, with its word formed from the prefetched byte or
// read afresh from block memory; a candidate check follows a table hit, match
// extension reads and then compares one byte at a time, literal bytes go out
// one per cycle and a copy chunk writes two or three bytes, bounded by the
// single write port of the output memory. Fetch requests (kind 1) then each
// read the output memory; each returns one stream byte on result for one cycle
// with strobe high, which the receiver must take as it comes. Busy stays high
// until that byte is out, so no new fetch is taken before it.
`include "assert_macros.svh"
module snappy_block_compressor import snpc_pkg::*; #(
  parameter int MAX_BLOCK = 65536,
  parameter int HASH_BITS = 15,
  parameter int OUT_DEPTH = 81920
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t request,
  output logic strobe,
  output res_t result
);

  localparam int ABITS = $clog2(MAX_BLOCK);
  localparam int OBITS = $clog2(OUT_DEPTH);
  localparam int OLW   = $clog2(OUT_DEPTH + 1);

  // memories
  logic [7:0] bs_mem [MAX_BLOCK];
  logic [7:0] os_mem [OUT_DEPTH];

  state_t state, state_next;
  logic [POS_W-1:0] bl, bl_next, v, v_next, ip, ip_next, done, done_next;
  logic [POS_W-1:0] cand, cand_next, len, len_next, lstart, lstart_next;
  logic [POS_W-1:0] llen, llen_next, li, li_next, crem, crem_next;
  logic [31:0] wrd, wrd_next;
  logic pend, pend_next, ret_copy, ret_copy_next, eq, eq_next, ovf, ovf_next;
  logic [1:0] lnb, lnb_next, lj, lj_next, cb, cb_next;
  logic [15:0] offs, offs_next;
  logic [OLW-1:0] out_len, rp, rp_next;

  logic bs_we, ra_en, rb_en, pb_en, os_re;
  logic [POS_W-1:0] ra_addr, rb_addr;
  logic [7:0] rd_a, rd_b, rd_o, pb_data;
  hash_req_t hreq;
  hash_rsp_t hrsp;

  logic accept;
  logic [POS_W:0] ip_w, n_w;
  logic [POS_W-1:0] m, seen_pos, offs_full, ip_len;
  logic [6:0] take;
  logic form1, fin, fetch_ok;

  assign accept = start && !busy;
  assign fetch_ok = accept && (request.kind == KIND_FETCH) && (rp < out_len);
  assign ip_w   = {1'b0, ip};
  assign n_w    = {1'b0, bl};
  assign m      = llen - 1'b1;
  assign seen_pos  = hrsp.seen - 1'b1;
  assign offs_full = ip - seen_pos;
  assign ip_len    = ip + len;
  assign take   = (crem >= POS_W'(64)) ? 7'd64 : crem[6:0];
  assign form1  = (take >= 7'd4) && (take <= 7'd11) && (offs < 16'd2048);
  assign fin    = (rp + 1'b1) >= out_len;

  snpc_hash #(.HASH_BITS(HASH_BITS)) u_hash (
    .clk  (clk),
    .rst  (rst),
    .hreq (hreq),
    .hrsp (hrsp)
  );

  // block memory: load write port, two read ports
  always_ff @(posedge clk) begin
    if (bs_we) bs_mem[bl[ABITS-1:0]] <= request.in_byte;
    if (ra_en) rd_a <= bs_mem[ra_addr[ABITS-1:0]];
    if (rb_en) rd_b <= bs_mem[rb_addr[ABITS-1:0]];
  end

  // output memory: stream write, drain read
  always_ff @(posedge clk) begin
    if (pb_en && (out_len < OLW'(OUT_DEPTH))) os_mem[out_len[OBITS-1:0]] <= pb_data;
    if (os_re) rd_o <= os_mem[rp[OBITS-1:0]];
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      bl      <= '0;
      rp      <= '0;
      ovf     <= 1'b0;
      out_len <= '0;
    end else begin
      state <= state_next;
      bl    <= bl_next;
      rp    <= rp_next;
      ovf   <= ovf_next;
      if (state == ST_LOAD && state_next == ST_HDR) begin
        out_len <= '0;
      end else if (pb_en && (out_len < OLW'(OUT_DEPTH))) begin
        out_len <= out_len + 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    v <= v_next; ip <= ip_next; done <= done_next; cand <= cand_next;
    len <= len_next; lstart <= lstart_next; llen <= llen_next; li <= li_next;
    crem <= crem_next; wrd <= wrd_next; pend <= pend_next;
    ret_copy <= ret_copy_next; eq <= eq_next; lnb <= lnb_next; lj <= lj_next;
    cb <= cb_next; offs <= offs_next;
  end

  // sequencer
  always_comb begin
    state_next = state;
    bl_next = bl; rp_next = rp; ovf_next = ovf; v_next = v; ip_next = ip;
    done_next = done; cand_next = cand; len_next = len; lstart_next = lstart;
    llen_next = llen; li_next = li; crem_next = crem; wrd_next = wrd;
    pend_next = pend; ret_copy_next = ret_copy; eq_next = eq; lnb_next = lnb;
    lj_next = lj; cb_next = cb; offs_next = offs;
    bs_we = 1'b0; ra_en = 1'b0; rb_en = 1'b0; ra_addr = ip; rb_addr = ip;
    pb_en = 1'b0; pb_data = '0; os_re = 1'b0;
    hreq = '0; hreq.word = wrd; hreq.pos1 = ip + 1'b1;
    strobe = 1'b0; result = '0;
    busy = 1'b1;
    case (state)
      ST_LOAD: begin
        busy = 1'b0;
        if (accept && request.kind == KIND_LOAD) begin
          if (bl < POS_W'(MAX_BLOCK)) begin
            bs_we   = 1'b1;
            bl_next = bl + 1'b1;
          end else begin
            ovf_next = 1'b1;
          end
          if (request.in_last) begin
            v_next     = bl_next;
            state_next = ST_HDR;
          end
        end
      end
      // length varint
      ST_HDR: begin
        pb_en = 1'b1;
        if (v >= POS_W'(8'h80)) begin
          pb_data = {1'b1, v[6:0]};
          v_next  = v >> 7;
        end else begin
          pb_data = v[7:0];
          if (bl < POS_W'(MIN_BLOCK)) begin
            lstart_next = '0; llen_next = bl; ret_copy_next = 1'b0;
            state_next  = ST_LIT_HDR;
          end else begin
            hreq.clear = 1'b1;
            state_next = ST_CLEAR;
          end
        end
      end
      ST_CLEAR: begin
        if (!hrsp.busy) begin
          ip_next = '0; done_next = '0;
          state_next = ST_TOP;
        end
      end
      ST_TOP: begin
        if (ip_w + 18'd4 <= n_w) begin
          state_next = ST_WRD0;
        end else begin
          lstart_next = done; llen_next = bl - done; ret_copy_next = 1'b0;
          state_next  = ST_LIT_HDR;
        end
      end
      // word at ip
      ST_WRD0: begin
        ra_en = 1'b1; rb_en = 1'b1; rb_addr = ip + 1'b1;
        state_next = ST_WRD1;
      end
      ST_WRD1: begin
        ra_en = 1'b1; rb_en = 1'b1; ra_addr = ip + 2'd2; rb_addr = ip + 2'd3;
        wrd_next[15:0] = {rd_b, rd_a};
        state_next = ST_WRD2;
      end
      ST_WRD2: begin
        wrd_next[31:16] = {rd_b, rd_a};
        state_next = ST_LOOK;
      end
      // table lookup, prefetch of the byte that slides in
      ST_LOOK: begin
        hreq.look = 1'b1;
        ra_en = 1'b1; ra_addr = ip + 3'd4;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (hrsp.hit_valid) begin
          if (hrsp.seen == '0 || seen_pos >= ip || offs_full[16]) begin
            ip_next = ip + 1'b1;
            if (ip_w + 18'd5 <= n_w) begin
              wrd_next   = {rd_a, wrd[31:8]};
              state_next = ST_LOOK;
            end else begin
              state_next = ST_TOP;
            end
          end else begin
            cand_next  = seen_pos;
            offs_next  = offs_full[15:0];
            state_next = ST_CW0;
          end
        end
      end
      // candidate word check
      ST_CW0: begin
        ra_en = 1'b1; rb_en = 1'b1; ra_addr = cand; rb_addr = cand + 1'b1;
        state_next = ST_CW1;
      end
      ST_CW1: begin
        ra_en = 1'b1; rb_en = 1'b1; ra_addr = cand + 2'd2; rb_addr = cand + 2'd3;
        eq_next = ({rd_b, rd_a} == wrd[15:0]);
        state_next = ST_CW2;
      end
      ST_CW2: begin
        if (eq && ({rd_b, rd_a} == wrd[31:16])) begin
          len_next   = POS_W'(4);
          state_next = ST_EXT;
        end else begin
          ip_next    = ip + 1'b1;
          state_next = ST_TOP;
        end
      end
      // match extension
      ST_EXT: begin
        if (ip_len < bl) begin
          ra_en = 1'b1; rb_en = 1'b1; ra_addr = cand + len; rb_addr = ip_len;
          state_next = ST_EXTC;
        end else begin
          lstart_next = done; llen_next = ip - done; ret_copy_next = 1'b1;
          state_next  = ST_LIT_HDR;
        end
      end
      ST_EXTC: begin
        if (rd_a == rd_b) begin
          len_next   = len + 1'b1;
          state_next = ST_EXT;
        end else begin
          lstart_next = done; llen_next = ip - done; ret_copy_next = 1'b1;
          state_next  = ST_LIT_HDR;
        end
      end
      // literal tag
      ST_LIT_HDR: begin
        if (llen == '0) begin
          crem_next  = len; cb_next = '0;
          state_next = ret_copy ? ST_COPY : ST_END;
        end else if (m < POS_W'(60)) begin
          pb_en = 1'b1; pb_data = {m[5:0], 2'b00};
          li_next = '0; pend_next = 1'b0;
          state_next = ST_LIT_DAT;
        end else begin
          lnb_next = m[16] ? 2'd3 : ((m >= POS_W'(256)) ? 2'd2 : 2'd1);
          pb_en = 1'b1; pb_data = {6'd59 + {4'd0, lnb_next}, 2'b00};
          lj_next = '0;
          state_next = ST_LIT_LEN;
        end
      end
      ST_LIT_LEN: begin
        pb_en = 1'b1;
        case (lj)
          2'd0:    pb_data = m[7:0];
          2'd1:    pb_data = m[15:8];
          default: pb_data = {7'd0, m[16]};
        endcase
        lj_next = lj + 1'b1;
        if (lj == lnb - 1'b1) begin
          li_next = '0; pend_next = 1'b0;
          state_next = ST_LIT_DAT;
        end
      end
      // literal bytes, read and write overlapped
      ST_LIT_DAT: begin
        if (pend) begin
          pb_en = 1'b1; pb_data = rd_a;
        end
        if (li < llen) begin
          ra_en = 1'b1; ra_addr = lstart + li;
          li_next = li + 1'b1; pend_next = 1'b1;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            crem_next  = len; cb_next = '0;
            state_next = ret_copy ? ST_COPY : ST_END;
          end
        end
      end
      // copy chunks
      ST_COPY: begin
        pb_en = 1'b1;
        case (cb)
          2'd0: begin
            if (form1) pb_data = {offs[10:8], 3'(take - 7'd4), 2'b01};
            else pb_data = {6'(take - 7'd1), 2'b10};
          end
          2'd1:    pb_data = offs[7:0];
          default: pb_data = offs[15:8];
        endcase
        cb_next = cb + 1'b1;
        if ((form1 && cb == 2'd1) || cb == 2'd2) begin
          cb_next   = '0;
          crem_next = crem - POS_W'(take);
          if (crem == POS_W'(take)) begin
            ip_next = ip_len; done_next = ip_len;
            state_next = ST_TOP;
          end
        end
      end
      ST_END: begin
        rp_next    = '0;
        state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        busy = 1'b0;
        if (fetch_ok) begin
          os_re      = 1'b1;
          state_next = ST_FOUT;
        end
      end
      ST_FOUT: begin
        strobe = 1'b1;
        result.out_byte = rd_o;
        result.out_last = fin;
        result.overflow = ovf;
        rp_next    = rp + 1'b1;
        state_next = ST_DRAIN;
        if (fin) begin
          bl_next = '0; rp_next = '0; ovf_next = 1'b0;
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // checks
  `SNPC_ASSERT_NEXT(a_fetch_gives_result, state == ST_DRAIN && fetch_ok, strobe)
  `SNPC_ASSERT_NOW(a_out_cap, 1'b1, out_len <= OLW'(OUT_DEPTH))
  `SNPC_ASSERT_NOW(a_ext_in_block, state == ST_EXT, ip_len <= bl)
  `SNPC_ASSERT_NEXT(a_last_ends, strobe && result.out_last, state == ST_LOAD && bl == '0)

endmodule

/* tb/sv/tb_top.sv */
// self-checking testbench for snappy_block_compressor: loads blocks, drains streams
// depends on snpc_pkg and the compressor rtl; predicts every stream byte itself
`timescale 1ns / 100ps
module tb_top import snpc_pkg::*;;

  localparam int BLOCK_CAP  = 65536;
  localparam int HASH_W     = 15;
  localparam int IDLE_LIMIT = 1500000;

  typedef logic [7:0] byte_t;

  typedef struct {
    req_t r;
    bit   hold;
    bit   burst;
  } pend_t;

  logic clk, rst, start, busy, strobe;
  req_t request;
  res_t result;

  snappy_block_compressor dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .request(request), .strobe(strobe), .result(result)
  );

  // predictor state
  int unsigned hash_tab [1 << HASH_W];
  byte_t       loaded_q [$];
  byte_t       stream_q [$];
  bit          draining, ovf_seen;
  int unsigned rd_ptr;
  res_t        exp_q [$];
  pend_t       pend_q [$];

  int unsigned acc_cnt, sent_cnt, gap, idle_cycles, fails;
  int unsigned n_blocks, n_bytes, n_results;
  bit          run_done;

  // clock and reset
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk) rst = 1'b0;
  end

  function automatic int unsigned word_at(ref byte_t s[$], input int unsigned p);
    return {s[p + 3], s[p + 2], s[p + 1], s[p]};
  endfunction

  function automatic void lit_out(ref byte_t s[$], ref byte_t d[$],
                                  input int unsigned from, input int unsigned len);
    int unsigned m, nb;
    if (len == 0) return;
    m = len - 1;
    if (m < 60) begin
      d.insert(d.size(), byte_t'(m << 2));
    end else begin
      nb = 1;
      for (int unsigned i = m; i >= 256; i >>= 8) nb++;
      d.insert(d.size(), byte_t'((59 + nb) << 2));
      for (int unsigned i = 0; i < nb; i++) d.insert(d.size(), byte_t'(m >> (8 * i)));
    end
    for (int unsigned i = 0; i < len; i++) d.insert(d.size(), s[from + i]);
  endfunction

  function automatic void copy_out(ref byte_t d[$], input int unsigned offset,
                                   input int unsigned len);
    int unsigned take;
    while (len > 0) begin
      take = (len < 64) ? len : 64;
      if (take >= 4 && take <= 11 && offset < 2048) begin
        d.insert(d.size(), byte_t'(((offset >> 8) << 5) | ((take - 4) << 2) | 1));
        d.insert(d.size(), byte_t'(offset));
      end else begin
        d.insert(d.size(), byte_t'(((take - 1) << 2) | 2));
        d.insert(d.size(), byte_t'(offset));
        d.insert(d.size(), byte_t'(offset >> 8));
      end
      len -= take;
    end
  endfunction

  // compressed stream of a whole block
  function automatic void compress_block(ref byte_t s[$], ref byte_t d[$]);
    int unsigned n, v, ip, done, w, h, seen, cand, offset, len;
    logic [31:0] prod;
    n = s.size();
    v = n;
    ip = 0;
    done = 0;
    d.delete();
    while (v >= 'h80) begin
      d.insert(d.size(), byte_t'((v & 'h7F) | 'h80));
      v >>= 7;
    end
    d.insert(d.size(), byte_t'(v));
    if (n < MIN_BLOCK) begin
      lit_out(s, d, 0, n);
      return;
    end
    foreach (hash_tab[i]) hash_tab[i] = 0;
    while (ip + 4 <= n) begin
      w = word_at(s, ip);
      prod = w * HASH_MUL;
      h = prod >> (32 - HASH_W);
      seen = hash_tab[h];
      hash_tab[h] = ip + 1;
      if (seen == 0 || seen - 1 >= ip) begin
        ip++;
        continue;
      end
      cand = seen - 1;
      offset = ip - cand;
      if (offset > 65535 || word_at(s, cand) != w) begin
        ip++;
        continue;
      end
      len = 4;
      while (ip + len < n && s[cand + len] == s[ip + len]) len++;
      lit_out(s, d, done, ip - done);
      copy_out(d, offset, len);
      ip += len;
      done = ip;
    end
    lit_out(s, d, done, n - done);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic pend_t mk_item(logic k, byte_t b, logic l);
    pend_t p;
    p.r.kind = k;
    p.r.in_byte = b;
    p.r.in_last = l;
    p.hold = 1'b0;
    p.burst = 1'b0;
    return p;
  endfunction

  // queue one block: its loads, then exactly enough fetches to drain it, plus a stray fetch and load when noise is set
  function automatic int unsigned queue_block(ref byte_t data[$], input bit noise,
                                              input bit hold, input bit burst);
    byte_t kept [$];
    byte_t strm [$];
    pend_t p;
    int unsigned cnt, spot;
    cnt = 0;
    if (noise) begin
      pend_q.insert(pend_q.size(),
                    mk_item(KIND_FETCH, byte_t'($urandom), $urandom_range(0, 1)));
      cnt++;
    end
    foreach (data[i]) begin
      p = mk_item(KIND_LOAD, data[i], i == data.size() - 1);
      p.hold = hold && (i == 0);
      p.burst = burst;
      pend_q.insert(pend_q.size(), p);
      if (i < BLOCK_CAP) kept.insert(kept.size(), data[i]);
    end
    compress_block(kept, strm);
    spot = noise ? $urandom_range(0, strm.size() - 1) : strm.size();
    for (int unsigned i = 0; i < strm.size(); i++) begin
      // stray load while draining: ignored by the block
      if (i == spot)
        pend_q.insert(pend_q.size(),
                      mk_item(KIND_LOAD, byte_t'($urandom), $urandom_range(0, 1)));
      pend_q.insert(pend_q.size(),
                    mk_item(KIND_FETCH, byte_t'($urandom), $urandom_range(0, 1)));
    end
    return cnt + data.size() + strm.size();
  endfunction

  function automatic void fill_block(ref byte_t d[$], input int unsigned len,
                                     input int unsigned style);
    byte_t pat [$];
    int unsigned plen;
    d.delete();
    plen = $urandom_range(1, 12);
    for (int unsigned i = 0; i < plen; i++) pat.insert(pat.size(), byte_t'($urandom));
    for (int unsigned i = 0; i < len; i++) begin
      case (style)
        0: d.insert(d.size(), byte_t'($urandom));
        1: d.insert(d.size(), byte_t'($urandom_range(0, 2) ? pat[0] : pat[plen - 1]));
        2: d.insert(d.size(), pat[i % plen]);
        default: d.insert(d.size(), ($urandom_range(0, 9) == 0 || i < 8) ?
                          byte_t'($urandom) : d[i - $urandom_range(1, (i < 64) ? i : 64)]);
      endcase
    end
  endfunction

  // stimulus
  initial begin
    byte_t blk [$];
    int unsigned items, len;
    items = 0;
    // directed: tiny, edge of literal-only, repetitive, long literal
    blk = '{8'h00};
    items += queue_block(blk, 1'b0, 1'b0, 1'b0);
    fill_block(blk, 15, 0);
    items += queue_block(blk, 1'b1, 1'b0, 1'b0);
    fill_block(blk, 16, 0);
    items += queue_block(blk, 1'b0, 1'b1, 1'b0);
    fill_block(blk, 17, 2);
    items += queue_block(blk, 1'b0, 1'b0, 1'b0);
    blk.delete();
    for (int i = 0; i < 20; i++)
      blk.insert(blk.size(), byte_t'("abcd" >> (8 * (3 - i % 4))));
    items += queue_block(blk, 1'b0, 1'b0, 1'b0);
    blk.delete();
    for (int i = 0; i < 200; i++) blk.insert(blk.size(), 8'hFF);
    items += queue_block(blk, 1'b0, 1'b1, 1'b0);
    fill_block(blk, 300, 0);
    items += queue_block(blk, 1'b0, 1'b0, 1'b0);
    // random part, mostly short blocks since long ones pay a table clear
    while (items < 1800) begin
      len = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 15) : $urandom_range(16, 96);
      fill_block(blk, len, $urandom_range(0, 3));
      items += queue_block(blk, $urandom_range(0, 7) == 0, $urandom_range(0, 9) == 0,
                           $urandom_range(0, 4) == 0);
    end
  end

  // driver: changes inputs at the falling edge
  always @(negedge clk) begin
    logic nstart;
    nstart = start;
    if (rst !== 1'b0) begin
      nstart = 1'b0;
    end else if (!start || acc_cnt == sent_cnt) begin
      nstart = 1'b0;
      if (gap > 0) begin
        gap--;
      end else if (pend_q.size() > 0 &&
                   !(pend_q[0].hold && (exp_q.size() > 0 || draining))) begin
        request <= pend_q[0].r;
        gap = pend_q[0].burst ? 0 : pick_gap();
        void'(pend_q.pop_front());
        sent_cnt++;
        nstart = 1'b1;
      end
    end
    start <= nstart;
  end

  initial begin
    start = 1'b0;
    request = '0;
    acc_cnt = 0;
    sent_cnt = 0;
    gap = 0;
    draining = 1'b0;
    ovf_seen = 1'b0;
    rd_ptr = 0;
    fails = 0;
    n_blocks = 0;
    n_bytes = 0;
    n_results = 0;
    idle_cycles = 0;
    run_done = 1'b0;
  end

  // predictor update on each accepted request, and result checking
  always @(posedge clk) begin
    res_t want;
    if (!rst && start && !busy) begin
      acc_cnt++;
      if (request.kind == KIND_LOAD) begin
        if (!draining) begin
          n_bytes++;
          if (loaded_q.size() < BLOCK_CAP) loaded_q.insert(loaded_q.size(), request.in_byte);
          else ovf_seen = 1'b1;
          if (request.in_last) begin
            compress_block(loaded_q, stream_q);
            rd_ptr = 0;
            draining = 1'b1;
            n_blocks++;
          end
        end
      end else if (draining && rd_ptr < stream_q.size()) begin
        want.out_byte = stream_q[rd_ptr];
        want.out_last = (rd_ptr + 1 >= stream_q.size());
        want.overflow = ovf_seen;
        exp_q.insert(exp_q.size(), want);
        rd_ptr++;
        if (want.out_last) begin
          draining = 1'b0;
          loaded_q.delete();
          ovf_seen = 1'b0;
          rd_ptr = 0;
        end
      end
    end
    if (!rst && strobe) begin
      n_results++;
      if (exp_q.size() == 0) begin
        $error("unexpected result byte %0h", result.out_byte);
        fails++;
      end else begin
        want = exp_q.pop_front();
        if (result.out_byte !== want.out_byte) begin
          $error("out_byte: expected %0h, got %0h", want.out_byte, result.out_byte);
          fails++;
        end
        if (result.out_last !== want.out_last) begin
          $error("out_last: expected %0b, got %0b", want.out_last, result.out_last);
          fails++;
        end
        if (result.overflow !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, result.overflow);
          fails++;
        end
      end
    end
  end

  // watchdog on cycles with no request taken and no result seen
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (!run_done && idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", idle_cycles);
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // end of run
  initial begin
    @(negedge rst);
    wait (pend_q.size() == 0 && acc_cnt == sent_cnt && !start);
    wait (exp_q.size() == 0);
    repeat (20) @(posedge clk);
    run_done = 1'b1;
    if (exp_q.size() != 0) begin
      $error("%0d result bytes never arrived", exp_q.size());
      fails++;
    end
    $display("covered %0d blocks, %0d load bytes, %0d stream bytes checked",
             n_blocks, n_bytes, n_results);
    if (fails == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
